FILE: hw/rtl/fwpid_pkg.sv
package fwpid_pkg;

	localparam int SPEED_WIDTH = 16;
	localparam int WHEELS      = 4;
	localparam int GAIN_W      = 16;
	localparam int PERIOD_W    = 10;
	localparam int LIMIT_W     = 15;
	localparam int DRIVE_W     = 16;
	localparam int INTEG_W     = 16;
	localparam int ERR_W       = SPEED_WIDTH + 1;
	localparam int DIFF_W      = SPEED_WIDTH + 2;
	localparam int PROD_W      = GAIN_W + 1 + ERR_W;
	localparam int DPROD_W     = GAIN_W + 1 + DIFF_W;
	localparam int ACC_W       = DPROD_W + 2;
	localparam int ISUM_W      = PROD_W + 1;

	localparam int Q_DEPTH     = 4;
	localparam int Q_AW        = $clog2(Q_DEPTH);
	localparam int Q_CW        = $clog2(Q_DEPTH + 1);
	localparam int OUT_DEPTH   = 4;
	localparam int OUT_AW      = $clog2(OUT_DEPTH);
	localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP      = 3'd0,
		REG_GAIN_INT       = 3'd1,
		REG_GAIN_DERIV     = 3'd2,
		REG_UPDATE_PERIOD  = 3'd3,
		REG_DRIVE_LIMIT    = 3'd4,
		REG_INTEGRAL_LIMIT = 3'd5
	} cfg_idx_t;

	localparam logic [GAIN_W-1:0]   GAIN_PROP_RST      = 16'd1818;
	localparam logic [GAIN_W-1:0]   GAIN_INT_RST       = 16'd26;
	localparam logic [GAIN_W-1:0]   GAIN_DERIV_RST     = 16'd0;
	localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST  = 10'd20;
	localparam logic [LIMIT_W-1:0]  DRIVE_LIMIT_RST    = 15'd25600;
	localparam logic [LIMIT_W-1:0]  INTEGRAL_LIMIT_RST = 15'd15360;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain_prop;
		logic [GAIN_W-1:0]   gain_int;
		logic [GAIN_W-1:0]   gain_deriv;
		logic [PERIOD_W-1:0] update_period;
		logic [LIMIT_W-1:0]  drive_limit;
		logic [LIMIT_W-1:0]  integral_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [SPEED_WIDTH-1:0] target_a;
		logic signed [SPEED_WIDTH-1:0] target_b;
		logic signed [SPEED_WIDTH-1:0] target_c;
		logic signed [SPEED_WIDTH-1:0] target_d;
		logic signed [SPEED_WIDTH-1:0] measured_a;
		logic signed [SPEED_WIDTH-1:0] measured_b;
		logic signed [SPEED_WIDTH-1:0] measured_c;
		logic signed [SPEED_WIDTH-1:0] measured_d;
	} in_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive_a;
		logic signed [DRIVE_W-1:0] drive_b;
		logic signed [DRIVE_W-1:0] drive_c;
		logic signed [DRIVE_W-1:0] drive_d;
	} out_t;

	typedef struct packed {
		logic [WHEELS-1:0][ERR_W-1:0]  err;
		logic [WHEELS-1:0][DIFF_W-1:0] diff;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: hw/rtl/four_wheel_pid_speed_control.sv
// An update tick's result goes through queue write, multiply stage, sum stage, then
// integrator into the output queue; pops stall while output space is all reserved.
// Throughput: one tick per cycle while the work queue is not full; back-to-back updates
// are sustained because the integrator closes its loop through one register per wheel.
// Reset (arst_n low): tick counter, errors and integrals cleared, registers to defaults.
module four_wheel_pid_speed_control (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  fwpid_pkg::in_t                     tick,
	output logic                               empty,
	input  logic                               pop,
	output fwpid_pkg::out_t                    drive,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fwpid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fwpid_pkg::CFG_DATA_W-1:0]   cfg_data
);

	fwpid_pkg::cfg_t    cfg_q;
	fwpid_pkg::work_t   push_data;
	fwpid_pkg::work_t   pop_data;
	fwpid_pkg::q_stat_t q_stat;
	logic               accept;
	logic               q_push;
	logic               q_pop;

	assign cfg_ready = 1'b1;
	assign full      = q_stat.full;
	assign accept    = push && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop      <= fwpid_pkg::GAIN_PROP_RST;
			cfg_q.gain_int       <= fwpid_pkg::GAIN_INT_RST;
			cfg_q.gain_deriv     <= fwpid_pkg::GAIN_DERIV_RST;
			cfg_q.update_period  <= fwpid_pkg::UPDATE_PERIOD_RST;
			cfg_q.drive_limit    <= fwpid_pkg::DRIVE_LIMIT_RST;
			cfg_q.integral_limit <= fwpid_pkg::INTEGRAL_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fwpid_pkg::REG_GAIN_PROP: begin
					cfg_q.gain_prop <= cfg_data;
				end
				fwpid_pkg::REG_GAIN_INT: begin
					cfg_q.gain_int <= cfg_data;
				end
				fwpid_pkg::REG_GAIN_DERIV: begin
					cfg_q.gain_deriv <= cfg_data;
				end
				fwpid_pkg::REG_UPDATE_PERIOD: begin
					cfg_q.update_period <= cfg_data[fwpid_pkg::PERIOD_W-1:0];
				end
				fwpid_pkg::REG_DRIVE_LIMIT: begin
					cfg_q.drive_limit <= cfg_data[fwpid_pkg::LIMIT_W-1:0];
				end
				fwpid_pkg::REG_INTEGRAL_LIMIT: begin
					cfg_q.integral_limit <= cfg_data[fwpid_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	fwpid_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.tick          (tick),
		.update_period (cfg_q.update_period),
		.q_push        (q_push),
		.q_data        (push_data)
	);

	fwpid_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (push_data),
		.pop     (q_pop),
		.rd_data (pop_data),
		.stat    (q_stat)
	);

	fwpid_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_data  (pop_data),
		.q_empty (q_stat.empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.drive   (drive)
	);

`ifndef NO_ASSERTIONS
	a_q_stat: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_stat.empty)
		else $error("work queue full and empty at once");

	a_q_push: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("update pushed into a full work queue");

	a_q_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("back end popped an empty work queue");
`endif

endmodule

FILE: hw/rtl/fwpid_front.sv
module fwpid_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  fwpid_pkg::in_t                  tick,
	input  logic [fwpid_pkg::PERIOD_W-1:0]  update_period,
	output logic                            q_push,
	output fwpid_pkg::work_t                q_data
);

	logic [fwpid_pkg::PERIOD_W-1:0]          tick_count_q;
	logic [fwpid_pkg::PERIOD_W-1:0]          next_count;
	logic                                    upd;
	logic [fwpid_pkg::ERR_W-1:0]             last_err_q [fwpid_pkg::WHEELS];
	logic [fwpid_pkg::ERR_W-1:0]             err        [fwpid_pkg::WHEELS];
	logic [fwpid_pkg::SPEED_WIDTH-1:0]       tgt        [fwpid_pkg::WHEELS];
	logic [fwpid_pkg::SPEED_WIDTH-1:0]       mea        [fwpid_pkg::WHEELS];

	assign tgt[0] = tick.target_a;
	assign tgt[1] = tick.target_b;
	assign tgt[2] = tick.target_c;
	assign tgt[3] = tick.target_d;
	assign mea[0] = tick.measured_a;
	assign mea[1] = tick.measured_b;
	assign mea[2] = tick.measured_c;
	assign mea[3] = tick.measured_d;

	assign next_count = tick_count_q + fwpid_pkg::PERIOD_W'(1);
	assign upd        = next_count >= update_period;
	assign q_push     = accept && upd;

	always_comb begin
		for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
			err[w] = {tgt[w][fwpid_pkg::SPEED_WIDTH-1], tgt[w]}
			       - {mea[w][fwpid_pkg::SPEED_WIDTH-1], mea[w]};
			q_data.err[w]  = err[w];
			q_data.diff[w] = {err[w][fwpid_pkg::ERR_W-1], err[w]}
			               - {last_err_q[w][fwpid_pkg::ERR_W-1], last_err_q[w]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
				last_err_q[w] <= '0;
			end
		end else if (accept) begin
			tick_count_q <= upd ? '0 : next_count;
			if (upd) begin
				for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
					last_err_q[w] <= err[w];
				end
			end
		end
	end

endmodule

FILE: hw/rtl/fwpid_queue.sv
module fwpid_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fwpid_pkg::work_t   wr_data,
	input  logic               pop,
	output fwpid_pkg::work_t   rd_data,
	output fwpid_pkg::q_stat_t stat
);

	fwpid_pkg::work_t             mem [fwpid_pkg::Q_DEPTH];
	logic [fwpid_pkg::Q_AW-1:0]   wr_ptr_q;
	logic [fwpid_pkg::Q_AW-1:0]   rd_ptr_q;
	logic [fwpid_pkg::Q_CW-1:0]   cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign stat.full  = cnt_q == fwpid_pkg::Q_CW'(fwpid_pkg::Q_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_data    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + fwpid_pkg::Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + fwpid_pkg::Q_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + fwpid_pkg::Q_CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - fwpid_pkg::Q_CW'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/fwpid_back.sv
module fwpid_back (
	input  logic               clk,
	input  logic               arst_n,
	input  fwpid_pkg::cfg_t    cfg,
	input  fwpid_pkg::work_t   q_data,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output fwpid_pkg::out_t    drive
);

	logic                                   v_s1;
	logic                                   v_s2;
	logic signed [fwpid_pkg::PROD_W-1:0]    p_s1    [fwpid_pkg::WHEELS];
	logic signed [fwpid_pkg::DPROD_W-1:0]   d_s1    [fwpid_pkg::WHEELS];
	logic signed [fwpid_pkg::PROD_W-1:0]    i_s1    [fwpid_pkg::WHEELS];
	logic signed [fwpid_pkg::ACC_W-1:0]     pd_s2   [fwpid_pkg::WHEELS];
	logic signed [fwpid_pkg::PROD_W-1:0]    i_s2    [fwpid_pkg::WHEELS];
	logic signed [fwpid_pkg::INTEG_W-1:0]   integ_q [fwpid_pkg::WHEELS];

	logic signed [fwpid_pkg::ACC_W-1:0]     acc     [fwpid_pkg::WHEELS];
	logic signed [fwpid_pkg::ISUM_W-1:0]    isum    [fwpid_pkg::WHEELS];
	logic signed [fwpid_pkg::INTEG_W-1:0]   integ_nx[fwpid_pkg::WHEELS];
	logic signed [fwpid_pkg::DRIVE_W-1:0]   drv     [fwpid_pkg::WHEELS];
	logic signed [fwpid_pkg::ACC_W-1:0]     dl;
	logic signed [fwpid_pkg::ACC_W-1:0]     ndl;
	logic signed [fwpid_pkg::ISUM_W-1:0]    il;
	logic signed [fwpid_pkg::ISUM_W-1:0]    nil;

	fwpid_pkg::out_t                        ofifo   [fwpid_pkg::OUT_DEPTH];
	logic [fwpid_pkg::OUT_AW-1:0]           owr_q;
	logic [fwpid_pkg::OUT_AW-1:0]           ord_q;
	logic [fwpid_pkg::OUT_CW-1:0]           ocnt_q;
	logic [fwpid_pkg::OUT_CW-1:0]           inflight;
	logic                                   o_pop;

	// reserve output space for everything already in the pipeline
	assign inflight = ocnt_q + fwpid_pkg::OUT_CW'(v_s1) + fwpid_pkg::OUT_CW'(v_s2);
	assign q_pop    = !q_empty && (inflight < fwpid_pkg::OUT_CW'(fwpid_pkg::OUT_DEPTH));
	assign empty    = ocnt_q == '0;
	assign o_pop    = pop && !empty;
	assign drive    = ofifo[ord_q];

	assign dl  = fwpid_pkg::ACC_W'(cfg.drive_limit);
	assign ndl = -dl;
	assign il  = fwpid_pkg::ISUM_W'(cfg.integral_limit);
	assign nil = -il;

	always_comb begin
		for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
			acc[w]  = pd_s2[w] + fwpid_pkg::ACC_W'(integ_q[w]);
			isum[w] = fwpid_pkg::ISUM_W'(integ_q[w]);
			if (acc[w] > dl) begin
				drv[w] = fwpid_pkg::DRIVE_W'(dl);
			end else if (acc[w] < ndl) begin
				drv[w] = fwpid_pkg::DRIVE_W'(ndl);
			end else begin
				drv[w]  = fwpid_pkg::DRIVE_W'(acc[w]);
				isum[w] = isum[w] + fwpid_pkg::ISUM_W'(i_s2[w]);
			end
			if (isum[w] > il) begin
				integ_nx[w] = fwpid_pkg::INTEG_W'(il);
			end else if (isum[w] < nil) begin
				integ_nx[w] = fwpid_pkg::INTEG_W'(nil);
			end else begin
				integ_nx[w] = fwpid_pkg::INTEG_W'(isum[w]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
			p_s1[w]  <= $signed({1'b0, cfg.gain_prop}) * $signed(q_data.err[w]);
			i_s1[w]  <= $signed({1'b0, cfg.gain_int}) * $signed(q_data.err[w]);
			d_s1[w]  <= $signed({1'b0, cfg.gain_deriv}) * $signed(q_data.diff[w]);
			pd_s2[w] <= fwpid_pkg::ACC_W'(p_s1[w]) + fwpid_pkg::ACC_W'(d_s1[w]);
			i_s2[w]  <= i_s1[w];
		end
		if (v_s2) begin
			ofifo[owr_q] <= '{drive_a: drv[0], drive_b: drv[1],
			                  drive_c: drv[2], drive_d: drv[3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
			for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
				integ_q[w] <= '0;
			end
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			if (v_s2) begin
				owr_q <= owr_q + fwpid_pkg::OUT_AW'(1);
				for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
					integ_q[w] <= integ_nx[w];
				end
			end
			if (o_pop) begin
				ord_q <= ord_q + fwpid_pkg::OUT_AW'(1);
			end
			if (v_s2 && !o_pop) begin
				ocnt_q <= ocnt_q + fwpid_pkg::OUT_CW'(1);
			end else if (o_pop && !v_s2) begin
				ocnt_q <= ocnt_q - fwpid_pkg::OUT_CW'(1);
			end
		end
	end

endmodule

FILE: tb/four_wheel_pid_speed_control_tb.sv
`timescale 1ns / 100ps

module four_wheel_pid_speed_control_tb;

	import fwpid_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PHASES        = 16;
	localparam int PHASE_TICKS   = 95;

	typedef struct packed {
		bit                   is_cfg;
		cfg_idx_t             idx;
		logic [CFG_DATA_W-1:0] val;
		in_t                  stim;
		bit                   typed;
		out_t                 want;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	in_t                   tick;
	logic                  empty;
	logic                  pop;
	out_t                  drive;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	cfg_t                     shadow;
	logic [PERIOD_W-1:0]      tick_cnt;
	logic signed [ERR_W-1:0]  last_err [WHEELS];
	logic signed [INTEG_W-1:0] integ   [WHEELS];

	out_t   drive_q [$];
	out_t   want_drive;
	step_t  plan [$];
	bit     steady;
	bit     hold_drive;
	int     fails;
	int     n_ticks;
	int     n_drives;
	int     n_writes;
	int     n_phases;
	int     cycles;

	four_wheel_pid_speed_control u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.tick      (tick),
		.empty     (empty),
		.pop       (pop),
		.drive     (drive),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d drive items outstanding",
				cycles, drive_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic bit pid_update(input in_t t, output out_t o);
		longint tg [WHEELS];
		longint ms [WHEELS];
		longint err, dif, acc, ig, dv;
		longint kp, ki, kd, dlim, ilim;
		logic [DRIVE_W-1:0] dq [WHEELS];
		logic [PERIOD_W-1:0] nxt;
		tg[0] = t.target_a;
		tg[1] = t.target_b;
		tg[2] = t.target_c;
		tg[3] = t.target_d;
		ms[0] = t.measured_a;
		ms[1] = t.measured_b;
		ms[2] = t.measured_c;
		ms[3] = t.measured_d;
		kp = longint'(shadow.gain_prop);
		ki = longint'(shadow.gain_int);
		kd = longint'(shadow.gain_deriv);
		dlim = longint'(shadow.drive_limit);
		ilim = longint'(shadow.integral_limit);
		o = '0;
		nxt = tick_cnt + PERIOD_W'(1);
		if (nxt < shadow.update_period) begin
			tick_cnt = nxt;
			return 1'b0;
		end
		tick_cnt = '0;
		for (int w = 0; w < WHEELS; w++) begin
			err = tg[w] - ms[w];
			dif = err - longint'(last_err[w]);
			ig = longint'(integ[w]);
			acc = kp * err + ig + kd * dif;
			last_err[w] = ERR_W'(err);
			if (acc > dlim) begin
				dv = dlim;
			end else if (acc < -dlim) begin
				dv = -dlim;
			end else begin
				dv = acc;
				ig += ki * err;
			end
			if (ig > ilim) begin
				ig = ilim;
			end else if (ig < -ilim) begin
				ig = -ilim;
			end
			integ[w] = INTEG_W'(ig);
			dq[w] = dv[DRIVE_W-1:0];
		end
		o = {dq[0], dq[1], dq[2], dq[3]};
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return GAIN_W'($urandom_range(0, 1024));
			6, 7: return GAIN_W'($urandom_range(0, 4095));
			default: return GAIN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [LIMIT_W-1:0] pick_limit();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return '1;
			default: return LIMIT_W'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic logic [PERIOD_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return PERIOD_W'($urandom_range(1, 4));
		end else if (r < 8) begin
			return PERIOD_W'($urandom_range(5, 30));
		end else if (r == 8) begin
			return '0;
		end
		return PERIOD_W'($urandom_range(31, 1023));
	endfunction

	function automatic in_t rand_tick();
		logic [SPEED_WIDTH-1:0] g [WHEELS];
		logic [SPEED_WIDTH-1:0] m [WHEELS];
		int r;
		for (int w = 0; w < WHEELS; w++) begin
			m[w] = SPEED_WIDTH'($urandom);
			r = $urandom_range(0, 9);
			if (r < 6) begin
				g[w] = m[w] + SPEED_WIDTH'($urandom_range(0, 64)) - SPEED_WIDTH'(32);
			end else if (r < 8) begin
				g[w] = SPEED_WIDTH'($urandom);
			end else if (r == 8) begin
				g[w] = 16'h7FFF;
			end else begin
				g[w] = 16'h8000;
			end
		end
		return {g[0], g[1], g[2], g[3], m[0], m[1], m[2], m[3]};
	endfunction

	function automatic in_t mk_tick(input logic [15:0] a, b, c, d, ma, mb, mc, md);
		return {a, b, c, d, ma, mb, mc, md};
	endfunction

	function automatic void add_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.val = val;
		plan.push_back(s);
	endfunction

	function automatic void add_tick(input in_t t, input bit typed, input out_t want);
		step_t s;
		s = '0;
		s.stim = t;
		s.typed = typed;
		s.want = want;
		plan.push_back(s);
	endfunction

	task automatic check_field(input string nm, input logic [15:0] e, input logic [15:0] a);
		if (e !== a) begin
			$error("%s: expected %0d, actual %0d", nm, $signed(e), $signed(a));
			fails++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (drive_q.size() == 0) begin
				$error("drive item with none expected");
				fails++;
			end else begin
				want_drive = drive_q.pop_front();
				check_field("drive_a", want_drive.drive_a, drive.drive_a);
				check_field("drive_b", want_drive.drive_b, drive.drive_b);
				check_field("drive_c", want_drive.drive_c, drive.drive_c);
				check_field("drive_d", want_drive.drive_d, drive.drive_d);
				n_drives++;
			end
		end
	end

	// receiver
	initial begin
		int n;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_drive) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_drive = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					pop <= 1'b0;
					repeat (n) @(posedge clk);
				end
				pop <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic send_tick(input in_t t, input bit typed, input out_t want);
		out_t got;
		int gap;
		push <= 1'b1;
		tick <= t;
		@(posedge clk);
		while (full) @(posedge clk);
		if (pid_update(t, got)) begin
			drive_q.push_back(typed ? want : got);
		end
		n_ticks++;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for all expected drive items, then let the design settle
	task automatic drain();
		while (drive_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_GAIN_PROP:      shadow.gain_prop = val;
			REG_GAIN_INT:       shadow.gain_int = val;
			REG_GAIN_DERIV:     shadow.gain_deriv = val;
			REG_UPDATE_PERIOD:  shadow.update_period = val[PERIOD_W-1:0];
			REG_DRIVE_LIMIT:    shadow.drive_limit = val[LIMIT_W-1:0];
			REG_INTEGRAL_LIMIT: shadow.integral_limit = val[LIMIT_W-1:0];
			default: ;
		endcase
		n_writes++;
	endtask

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		push = 1'b0;
		tick = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		hold_drive = 1'b0;
		fails = 0;
		n_ticks = 0;
		n_drives = 0;
		n_writes = 0;
		n_phases = 0;
		cycles = 0;
		shadow = {GAIN_PROP_RST, GAIN_INT_RST, GAIN_DERIV_RST, UPDATE_PERIOD_RST,
			DRIVE_LIMIT_RST, INTEGRAL_LIMIT_RST};
		tick_cnt = '0;
		for (int w = 0; w < WHEELS; w++) begin
			last_err[w] = '0;
			integ[w] = '0;
		end

		// directed steps, reset gains with an update on every tick
		add_cfg(REG_UPDATE_PERIOD, 16'd1);
		add_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, {16'sd0, 16'sd0, 16'sd0, 16'sd0});
		add_tick(mk_tick(16'h7FFF, 16'h8000, 0, 1, 16'h8000, 16'h7FFF, 0, 0), 1'b1,
			{16'sd25600, -16'sd25600, 16'sd0, 16'sd1818});
		add_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, {16'sd0, 16'sd0, 16'sd0, 16'sd26});
		add_tick(mk_tick(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
			16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF), 1'b0, '0);
		add_tick(mk_tick(16'h0001, 16'hFFFF, 16'h0064, 16'hFF9C, 0, 0, 0, 0), 1'b0, '0);
		add_tick(mk_tick(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
			16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF), 1'b0, '0);
		// widest products
		add_cfg(REG_GAIN_DERIV, 16'hFFFF);
		add_cfg(REG_GAIN_PROP, 16'hFFFF);
		add_tick(mk_tick(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
			16'h8000, 16'h7FFF, 0, 0), 1'b0, '0);
		add_tick(mk_tick(16'h8000, 16'h7FFF, 0, 0, 16'h7FFF, 16'h8000, 0, 0), 1'b0, '0);
		// integral runs into its clamp
		add_cfg(REG_GAIN_DERIV, 16'd0);
		add_cfg(REG_GAIN_PROP, 16'd0);
		add_cfg(REG_GAIN_INT, 16'hFFFF);
		for (int i = 0; i < 3; i++) begin
			add_tick(mk_tick(1, 1, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0), 1'b0, '0);
		end
		// lowered integral limit applies even with the output clamped
		add_cfg(REG_GAIN_PROP, 16'hFFFF);
		add_cfg(REG_INTEGRAL_LIMIT, 16'd100);
		add_tick(mk_tick(16'h0100, 16'hFF00, 16'h0001, 16'hFFFF, 0, 0, 0, 0), 1'b0, '0);
		// zero limits
		add_cfg(REG_DRIVE_LIMIT, 16'd0);
		add_cfg(REG_INTEGRAL_LIMIT, 16'd0);
		add_tick(mk_tick(16'h7FFF, 16'h8000, 1, 0, 0, 0, 0, 0), 1'b1, '0);
		add_tick(mk_tick(0, 0, 0, 0, 16'h1234, 16'h8000, 16'h7FFF, 0), 1'b1, '0);
		// period zero updates on every tick
		add_cfg(REG_DRIVE_LIMIT, 16'h7FFF);
		add_cfg(REG_INTEGRAL_LIMIT, 16'h7FFF);
		add_cfg(REG_UPDATE_PERIOD, 16'd0);
		add_tick(mk_tick(16'h0010, 16'hFFF0, 16'h0003, 16'h8000,
			0, 0, 16'hFFFD, 16'h8000), 1'b0, '0);
		add_tick(mk_tick(16'h0020, 16'hFFE0, 0, 16'h7FFF, 16'h0010, 0, 0, 16'h7FF0), 1'b0, '0);
		// period dropped below a running count
		add_cfg(REG_UPDATE_PERIOD, 16'd1023);
		for (int i = 0; i < 3; i++) begin
			add_tick(mk_tick(16'h0040, 16'h0040, 16'h0040, 16'h0040, 0, 0, 0, 0), 1'b0, '0);
		end
		add_cfg(REG_UPDATE_PERIOD, 16'd2);
		add_tick(mk_tick(16'h0004, 16'hFFFC, 16'h0100, 16'hFF00, 0, 0, 0, 0), 1'b0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				push <= 1'b0;
				drain();
				write_reg(plan[i].idx, plan[i].val);
				cfg_valid <= 1'b0;
			end else begin
				send_tick(plan[i].stim, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			push <= 1'b0;
			drain();
			steady = 1'b0;
			case (ph)
				0: c = {GAIN_PROP_RST, GAIN_INT_RST, GAIN_DERIV_RST, UPDATE_PERIOD_RST,
					DRIVE_LIMIT_RST, INTEGRAL_LIMIT_RST};
				1: c = {16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1, 15'h7FFF, 15'h7FFF};
				2: c = {16'h0000, 16'h0000, 16'h0000, 10'd1, 15'h0000, 15'h0000};
				default: begin
					c.gain_prop = pick_gain();
					c.gain_int = pick_gain();
					c.gain_deriv = pick_gain();
					c.update_period = pick_period();
					c.drive_limit = pick_limit();
					c.integral_limit = pick_limit();
				end
			endcase
			if (ph == 3) begin
				c.update_period = 10'd1;
			end
			write_reg(REG_GAIN_PROP, c.gain_prop);
			write_reg(REG_GAIN_INT, c.gain_int);
			write_reg(REG_GAIN_DERIV, c.gain_deriv);
			write_reg(REG_UPDATE_PERIOD, CFG_DATA_W'(c.update_period));
			write_reg(REG_DRIVE_LIMIT, CFG_DATA_W'(c.drive_limit));
			write_reg(REG_INTEGRAL_LIMIT, CFG_DATA_W'(c.integral_limit));
			cfg_valid <= 1'b0;
			n_phases++;
			if (ph == 3) begin
				steady = 1'b1;
				hold_drive = 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				steady = 1'b1;
			end
			for (int k = 0; k < PHASE_TICKS; k++) begin
				if (k == PHASE_TICKS / 2) begin
					push <= 1'b0;
					while (drive_q.size() != 0) @(posedge clk);
				end
				send_tick(rand_tick(), 1'b0, '0);
			end
		end

		push <= 1'b0;
		steady = 1'b0;
		drain();
		$display("%0d ticks over %0d random settings and the directed steps,",
			n_ticks, n_phases);
		$display("%0d drive items checked, %0d register writes", n_drives, n_writes);
		if (fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/fwpid_pkg.sv
hw/rtl/fwpid_front.sv
hw/rtl/fwpid_queue.sv
hw/rtl/fwpid_back.sv
hw/rtl/four_wheel_pid_speed_control.sv
tb/four_wheel_pid_speed_control_tb.sv
